### rtl/vbf_pkg.sv
// ----------------------------------------------------------------------------
// vbf_pkg
// Shared types and constants for the voxel boundary face extractor.
// ----------------------------------------------------------------------------
package vbf_pkg;

	localparam int ID_W  = 16;
	localparam int CRD_W = 6;
	localparam int POS_W = 5;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_PROC  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TRI    = 1'b1;

	localparam logic [2:0] FACE_TBL [6][4] = '{
		'{3'd2, 3'd0, 3'd4, 3'd6},
		'{3'd1, 3'd3, 3'd7, 3'd5},
		'{3'd0, 3'd1, 3'd5, 3'd4},
		'{3'd3, 3'd2, 3'd6, 3'd7},
		'{3'd0, 3'd2, 3'd3, 3'd1},
		'{3'd4, 3'd5, 3'd7, 3'd6}
	};

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_LADDR,
		S_LWR,
		S_VADDR,
		S_VRD,
		S_VCHK,
		S_CADDR,
		S_CRD,
		S_CCHK,
		S_CNEW,
		S_TRI
	} vbf_state_t;

	function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [1:0] k);
		face_corner = FACE_TBL[f][k];
	endfunction

endpackage

### rtl/voxel_boundary_faces.sv
// Load: address state, then write state. Clear: all corners, one corner per cycle.
// Process: each voxel read (center plus each inner neighbor) passes the address, read
// and check states, a border face is settled in the address state, each corner passes
// the address, read and check states plus a write state when new, then triangles face by
// face, all in series through the single address unit and memory port.
// Output stalls hold the sequencer. After reset the block sweeps the corner store.
// ----------------------------------------------------------------------------
// voxel_boundary_faces
// Boundary surface extraction: exposed faces of occupied voxels become
// vertex and triangle words.
// ----------------------------------------------------------------------------
module voxel_boundary_faces #(
	parameter int MAX_X = 32,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // pos_x, pos_y, pos_z, occupied
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // id_first, id_second, id_third, corner_x, corner_y, corner_z
	output logic        m_tuser,   // kind
	output logic        m_tlast
);

	localparam int VOX_DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int CRN_DEPTH = (MAX_X + 1) * (MAX_Y + 1) * (MAX_Z + 1);
	localparam int VOX_AW    = (VOX_DEPTH > 1) ? $clog2(VOX_DEPTH) : 1;
	localparam int CRN_AW    = $clog2(CRN_DEPTH);
	localparam int IW        = vbf_pkg::ID_W;
	localparam int CW        = vbf_pkg::CRD_W;

	vbf_pkg::vbf_state_t state_q, state_d;

	logic [CW-1:0]     size_x_q, size_y_q, size_z_q;
	logic [CW-1:0]     sx, sy, sz;
	logic [CW-1:0]     px_q, py_q, pz_q;
	logic              occ_q;
	logic [2:0]        step_q;
	logic              half_q;
	logic [5:0]        exposed_q;
	logic [IW-1:0]     ids_q [8];
	logic [IW-1:0]     next_id_q;
	logic [CRN_AW-1:0] clr_q;
	logic              vrd_q;
	logic [IW:0]       crd_q;

	logic              vmem [VOX_DEPTH];
	logic [IW:0]       cmem [CRN_DEPTH];

	logic              accept;
	logic [CW-1:0]     in_x, in_y, in_z;
	logic              in_range;
	logic [2:0]        fidx;
	logic              border;
	logic              set_bit;
	logic [5:0]        exp_nxt;
	logic [CW-1:0]     lx, ly, lz;
	logic              addr_ld, addr_sel;
	logic [CRN_AW-1:0] addr_s1;
	logic              out_free;
	logic              out_ld;
	logic              cm_we;
	logic [CRN_AW-1:0] cm_wa;
	logic [IW:0]       cm_wd;
	logic [IW-1:0]     p1, p2, p3, p4;
	logic [5:0]        hi_mask;
	logic              last_face;

	function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v, input int mx);
		if (v == '0) begin
			clamp = CW'(1);
		end else if ({3'b0, v} > 9'(mx)) begin
			clamp = CW'(mx);
		end else begin
			clamp = v;
		end
	endfunction

	assign sx = clamp(size_x_q, MAX_X);
	assign sy = clamp(size_y_q, MAX_Y);
	assign sz = clamp(size_z_q, MAX_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= CW'(32);
			size_y_q <= CW'(32);
			size_z_q <= CW'(32);
		end else if (cfg_we) begin
			case (cfg_addr)
				2'd0: size_x_q <= cfg_wdata;
				2'd1: size_y_q <= cfg_wdata;
				2'd2: size_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == vbf_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_x     = {1'b0, s_tdata[4:0]};
	assign in_y     = {1'b0, s_tdata[9:5]};
	assign in_z     = {1'b0, s_tdata[14:10]};
	assign in_range = (in_x < sx) && (in_y < sy) && (in_z < sz);
	assign out_free = !m_tvalid || m_tready;
	assign out_ld   = out_free && (state_q == vbf_pkg::S_CNEW ||
	                  (state_q == vbf_pkg::S_TRI && exposed_q[step_q]));

	assign fidx    = step_q - 3'd1;
	assign hi_mask = ~((6'd2 << step_q) - 6'd1);
	assign last_face = (exposed_q & hi_mask) == '0;
	assign p1 = ids_q[vbf_pkg::face_corner(step_q, 2'd0)];
	assign p2 = ids_q[vbf_pkg::face_corner(step_q, 2'd1)];
	assign p3 = ids_q[vbf_pkg::face_corner(step_q, 2'd2)];
	assign p4 = ids_q[vbf_pkg::face_corner(step_q, 2'd3)];

	always_comb begin
		border = 1'b0;
		lx = px_q;
		ly = py_q;
		lz = pz_q;
		unique case (step_q)
			3'd1: begin border = (px_q == '0); lx = px_q - CW'(1); end
			3'd2: begin border = (px_q + CW'(1) >= sx); lx = px_q + CW'(1); end
			3'd3: begin border = (py_q == '0); ly = py_q - CW'(1); end
			3'd4: begin border = (py_q + CW'(1) >= sy); ly = py_q + CW'(1); end
			3'd5: begin border = (pz_q == '0); lz = pz_q - CW'(1); end
			3'd6: begin border = (pz_q + CW'(1) >= sz); lz = pz_q + CW'(1); end
			default: ;
		endcase
		if (state_q == vbf_pkg::S_CADDR) begin
			lx = px_q + CW'(step_q[0]);
			ly = py_q + CW'(step_q[1]);
			lz = pz_q + CW'(step_q[2]);
		end
	end

	always_comb begin
		state_d  = state_q;
		addr_ld  = 1'b0;
		addr_sel = 1'b0;
		set_bit  = 1'b0;
		cm_we    = 1'b0;
		cm_wa    = addr_s1;
		cm_wd    = {1'b1, next_id_q};
		unique case (state_q)
			vbf_pkg::S_CLR: begin
				cm_we = 1'b1;
				cm_wa = clr_q;
				cm_wd = '0;
				if (clr_q == CRN_AW'(CRN_DEPTH - 1)) begin
					state_d = vbf_pkg::S_IDLE;
				end
			end
			vbf_pkg::S_IDLE: begin
				if (accept) begin
					if (s_tuser == vbf_pkg::CMD_CLEAR) begin
						state_d = vbf_pkg::S_CLR;
					end else if (in_range && s_tuser == vbf_pkg::CMD_LOAD) begin
						state_d = vbf_pkg::S_LADDR;
					end else if (in_range && s_tuser == vbf_pkg::CMD_PROC) begin
						state_d = vbf_pkg::S_VADDR;
					end
				end
			end
			vbf_pkg::S_LADDR: begin
				addr_ld = 1'b1;
				state_d = vbf_pkg::S_LWR;
			end
			vbf_pkg::S_LWR: begin
				state_d = vbf_pkg::S_IDLE;
			end
			vbf_pkg::S_VADDR: begin
				if (step_q != 3'd0 && border) begin
					set_bit = 1'b1;
					if (step_q == 3'd6) begin
						state_d = vbf_pkg::S_CADDR;
					end
				end else begin
					addr_ld = 1'b1;
					state_d = vbf_pkg::S_VRD;
				end
			end
			vbf_pkg::S_VRD: begin
				state_d = vbf_pkg::S_VCHK;
			end
			vbf_pkg::S_VCHK: begin
				if (step_q == 3'd0) begin
					state_d = vrd_q ? vbf_pkg::S_VADDR : vbf_pkg::S_IDLE;
				end else begin
					set_bit = !vrd_q;
					state_d = (step_q == 3'd6) ? vbf_pkg::S_CADDR : vbf_pkg::S_VADDR;
				end
			end
			vbf_pkg::S_CADDR: begin
				addr_ld  = 1'b1;
				addr_sel = 1'b1;
				state_d  = vbf_pkg::S_CRD;
			end
			vbf_pkg::S_CRD: begin
				state_d = vbf_pkg::S_CCHK;
			end
			vbf_pkg::S_CCHK: begin
				if (!crd_q[IW]) begin
					state_d = vbf_pkg::S_CNEW;
				end else begin
					state_d = (step_q == 3'd7) ? vbf_pkg::S_TRI : vbf_pkg::S_CADDR;
				end
			end
			vbf_pkg::S_CNEW: begin
				if (out_free) begin
					cm_we   = 1'b1;
					state_d = (step_q == 3'd7) ? vbf_pkg::S_TRI : vbf_pkg::S_CADDR;
				end
			end
			vbf_pkg::S_TRI: begin
				if (!exposed_q[step_q]) begin
					if (step_q == 3'd5) begin
						state_d = vbf_pkg::S_IDLE;
					end
				end else if (out_free && half_q && (step_q == 3'd5 || last_face)) begin
					state_d = vbf_pkg::S_IDLE;
				end
			end
			default: state_d = vbf_pkg::S_IDLE;
		endcase
		exp_nxt = exposed_q | (set_bit ? (6'b1 << fidx) : 6'b0);
		if ((state_q == vbf_pkg::S_VADDR || state_q == vbf_pkg::S_VCHK) &&
		    state_d == vbf_pkg::S_CADDR && exp_nxt == '0) begin
			state_d = vbf_pkg::S_IDLE;
		end
	end

	vbf_addr #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z),
		.AW    (CRN_AW)
	) u_addr (
		.clk     (clk),
		.ld      (addr_ld),
		.corner  (addr_sel),
		.x       (lx),
		.y       (ly),
		.z       (lz),
		.addr_s1 (addr_s1)
	);

	always_ff @(posedge clk) begin
		if (state_q == vbf_pkg::S_LWR) begin
			vmem[addr_s1[VOX_AW-1:0]] <= occ_q;
		end
		if (state_q == vbf_pkg::S_VRD) begin
			vrd_q <= vmem[addr_s1[VOX_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cmem[cm_wa] <= cm_wd;
		end
		if (state_q == vbf_pkg::S_CRD) begin
			crd_q <= cmem[addr_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vbf_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			next_id_q <= '0;
			step_q    <= '0;
			half_q    <= 1'b0;
			exposed_q <= '0;
			m_tvalid  <= 1'b0;
		end else begin
			if (m_tready && !out_ld) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				vbf_pkg::S_CLR: begin
					clr_q <= clr_q + CRN_AW'(1);
				end
				vbf_pkg::S_IDLE: begin
					if (accept) begin
						px_q      <= in_x;
						py_q      <= in_y;
						pz_q      <= in_z;
						occ_q     <= s_tdata[15];
						step_q    <= '0;
						half_q    <= 1'b0;
						exposed_q <= '0;
						if (s_tuser == vbf_pkg::CMD_CLEAR) begin
							clr_q     <= '0;
							next_id_q <= '0;
						end
					end
				end
				vbf_pkg::S_VADDR, vbf_pkg::S_VCHK: begin
					exposed_q <= exp_nxt;
					if (state_d == vbf_pkg::S_CADDR) begin
						step_q <= '0;
					end else if (state_d == vbf_pkg::S_VADDR) begin
						step_q <= step_q + 3'd1;
					end
				end
				vbf_pkg::S_CCHK: begin
					if (crd_q[IW]) begin
						ids_q[step_q] <= crd_q[IW-1:0];
						step_q <= step_q + 3'd1;
					end
				end
				vbf_pkg::S_CNEW: begin
					if (out_free) begin
						ids_q[step_q] <= next_id_q;
						next_id_q     <= next_id_q + IW'(1);
						step_q        <= step_q + 3'd1;
						m_tvalid      <= 1'b1;
						m_tuser       <= vbf_pkg::KIND_VERTEX;
						m_tlast       <= 1'b0;
						m_tdata       <= {6'b0, pz_q + CW'(step_q[2]), py_q + CW'(step_q[1]),
						                  px_q + CW'(step_q[0]), {2 * IW{1'b0}}, next_id_q};
					end
				end
				vbf_pkg::S_TRI: begin
					if (!exposed_q[step_q]) begin
						step_q <= step_q + 3'd1;
					end else if (out_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= vbf_pkg::KIND_TRI;
						m_tlast  <= half_q && last_face;
						m_tdata  <= half_q ? {24'b0, p1, p4, p3} : {24'b0, p3, p2, p1};
						half_q   <= !half_q;
						if (half_q) begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(next_id_q) |-> (next_id_q == $past(next_id_q) + IW'(1) || next_id_q == '0))
		else $error("vertex id counter skipped");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == vbf_pkg::KIND_VERTEX) |-> !m_tlast)
		else $error("vertex word marked last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vbf_pkg::S_CADDR || state_q == vbf_pkg::S_TRI) |-> exposed_q != '0)
		else $error("corner or triangle phase without exposed face");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vbf_pkg::S_CNEW && out_free) |=> m_tvalid)
		else $error("new corner without vertex word");

endmodule

### rtl/vbf_addr.sv
// ----------------------------------------------------------------------------
// vbf_addr
// Shared linear address unit for the voxel and corner stores, registered.
// ----------------------------------------------------------------------------
module vbf_addr #(
	parameter int MAX_X = 32,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 32,
	parameter int AW    = 16
) (
	input  logic                     clk,
	input  logic                     ld,
	input  logic                     corner,
	input  logic [vbf_pkg::CRD_W-1:0] x,
	input  logic [vbf_pkg::CRD_W-1:0] y,
	input  logic [vbf_pkg::CRD_W-1:0] z,
	output logic [AW-1:0]            addr_s1
);

	localparam int VSY = MAX_X;
	localparam int VSZ = MAX_X * MAX_Y;
	localparam int CSY = MAX_X + 1;
	localparam int CSZ = (MAX_X + 1) * (MAX_Y + 1);

	logic [AW-1:0] sy;
	logic [AW-1:0] sz;
	logic [AW-1:0] sum;

	assign sy  = corner ? AW'(CSY) : AW'(VSY);
	assign sz  = corner ? AW'(CSZ) : AW'(VSZ);
	assign sum = AW'(x) + AW'(AW'(y) * sy) + AW'(AW'(z) * sz);

	always_ff @(posedge clk) begin
		if (ld) begin
			addr_s1 <= sum;
		end
	end

endmodule

### dv/vbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbf_checker
// Watches the config port and both streams of the boundary face extractor,
// predicts the vertex and triangle words from its own copy of the voxel
// store and corner id table, and compares each output word in order.
// ----------------------------------------------------------------------------
module vbf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          fails,
	output int          pending
);

	localparam int NX = 32, NY = 32, NZ = 32;
	localparam int CX = NX + 1, CY = NY + 1, CZ = NZ + 1;
	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	typedef struct packed {
		logic                       kind;
		logic [vbf_pkg::ID_W-1:0]   id_a;
		logic [vbf_pkg::ID_W-1:0]   id_b;
		logic [vbf_pkg::ID_W-1:0]   id_c;
		logic [vbf_pkg::CRD_W-1:0]  crd_x;
		logic [vbf_pkg::CRD_W-1:0]  crd_y;
		logic [vbf_pkg::CRD_W-1:0]  crd_z;
		logic                       tail;
	} mesh_word_t;

	bit                       voxels [NX*NY*NZ];
	bit                       corner_set [CX*CY*CZ];
	logic [vbf_pkg::ID_W-1:0] corner_id [CX*CY*CZ];
	logic [vbf_pkg::ID_W-1:0] id_count;
	logic [5:0]               reg_sx, reg_sy, reg_sz;
	mesh_word_t               mesh_q [$];

	function automatic int eff_size(logic [5:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic bit solid_at(int x, int y, int z);
		return voxels[x + NX*y + NX*NY*z];
	endfunction

	task automatic add_word(logic k, logic [vbf_pkg::ID_W-1:0] a, logic [vbf_pkg::ID_W-1:0] b,
			logic [vbf_pkg::ID_W-1:0] c, int x, int y, int z);
		mesh_word_t w;
		w.kind  = k;
		w.id_a  = a;
		w.id_b  = b;
		w.id_c  = c;
		w.crd_x = x[vbf_pkg::CRD_W-1:0];
		w.crd_y = y[vbf_pkg::CRD_W-1:0];
		w.crd_z = z[vbf_pkg::CRD_W-1:0];
		w.tail  = 1'b0;
		mesh_q.push_back(w);
	endtask

	task automatic mesh_voxel(logic [1:0] cmd, logic [15:0] d);
		int x, y, z, sx, sy, sz, ci, cx, cy, cz, n0;
		bit open_face [6];
		bit any;
		logic [vbf_pkg::ID_W-1:0] ids [8];
		x  = d[4:0];
		y  = d[9:5];
		z  = d[14:10];
		sx = eff_size(reg_sx, NX);
		sy = eff_size(reg_sy, NY);
		sz = eff_size(reg_sz, NZ);
		if (cmd == vbf_pkg::CMD_CLEAR) begin
			foreach (corner_set[i]) corner_set[i] = 0;
			id_count = '0;
			return;
		end
		if (!(cmd == vbf_pkg::CMD_LOAD || cmd == vbf_pkg::CMD_PROC)) return;
		if (x >= sx || y >= sy || z >= sz) return;
		if (cmd == vbf_pkg::CMD_LOAD) begin
			voxels[x + NX*y + NX*NY*z] = d[15];
			return;
		end
		if (!solid_at(x, y, z)) return;
		open_face[0] = (x == 0) || !solid_at(x-1, y, z);
		open_face[1] = (x + 1 >= sx) || !solid_at(x+1, y, z);
		open_face[2] = (y == 0) || !solid_at(x, y-1, z);
		open_face[3] = (y + 1 >= sy) || !solid_at(x, y+1, z);
		open_face[4] = (z == 0) || !solid_at(x, y, z-1);
		open_face[5] = (z + 1 >= sz) || !solid_at(x, y, z+1);
		any = 0;
		foreach (open_face[f]) any |= open_face[f];
		if (!any) return;
		n0 = mesh_q.size();
		for (int c = 0; c < 8; c++) begin
			cx = x + (c & 1);
			cy = y + ((c >> 1) & 1);
			cz = z + ((c >> 2) & 1);
			ci = cx + CX*cy + CX*CY*cz;
			if (!corner_set[ci]) begin
				corner_set[ci] = 1;
				corner_id[ci]  = id_count;
				id_count++;
				add_word(vbf_pkg::KIND_VERTEX, corner_id[ci], '0, '0, cx, cy, cz);
			end
			ids[c] = corner_id[ci];
		end
		for (int f = 0; f < 6; f++) begin
			if (open_face[f]) begin
				add_word(vbf_pkg::KIND_TRI, ids[vbf_pkg::FACE_TBL[f][0]],
					ids[vbf_pkg::FACE_TBL[f][1]], ids[vbf_pkg::FACE_TBL[f][2]], 0, 0, 0);
				add_word(vbf_pkg::KIND_TRI, ids[vbf_pkg::FACE_TBL[f][2]],
					ids[vbf_pkg::FACE_TBL[f][3]], ids[vbf_pkg::FACE_TBL[f][0]], 0, 0, 0);
			end
		end
		if (mesh_q.size() > n0) mesh_q[mesh_q.size()-1].tail = 1'b1;
	endtask

	initial begin
		fails    = 0;
		id_count = '0;
		reg_sx   = 6'd32;
		reg_sy   = 6'd32;
		reg_sz   = 6'd32;
		foreach (corner_set[i]) corner_set[i] = 0;
	end

	assign pending = mesh_q.size();

	always @(posedge clk) begin
		mesh_word_t got, want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SIZE_X: reg_sx = cfg_wdata;
					REG_SIZE_Y: reg_sy = cfg_wdata;
					REG_SIZE_Z: reg_sz = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
					m_tdata[53:48], m_tdata[59:54], m_tdata[65:60], m_tlast};
				if (mesh_q.size() == 0) begin
					$display("%0t unexpected word: expected none, got %h", $time, got);
					fails++;
				end else begin
					want = mesh_q.pop_front();
					if (got !== want || m_tdata[71:66] !== '0) begin
						$display("%0t word mismatch: expected %h, got %h", $time, want, got);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) mesh_voxel(s_tuser, s_tdata);
		end
	end

endmodule

### dv/tb_voxel_boundary_faces.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_boundary_faces
// Drives loads, process and clear commands through several volume sizes,
// with bursty input, a stalling output and one long output hold-off; the
// checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_voxel_boundary_faces;

	localparam logic [1:0] CMD_NONE   = 2'd3;
	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;
	localparam logic [1:0] REG_SPARE  = 2'd3;
	localparam int SWEEP = 33*33*33 + 100;
	localparam int SETTLE = 200;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [5:0]  cfg_wdata;
	logic        s_tvalid, s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [71:0] m_tdata;
	logic        m_tuser, m_tlast;
	int          fails, pending;

	bit squeeze, squeezed;
	bit loaded [32768];
	bit solid [32768];
	int sx, sy, sz;
	int burst_left;
	int n_items;
	bit cleared;

	voxel_boundary_faces uut (.*);
	vbf_checker chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int mode, span;
			mode = $urandom_range(2);
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(posedge clk);
				if (squeeze && !squeezed) begin
					squeezed = 1;
					m_tready <= 1'b0;
					repeat (600) @(posedge clk);
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(1);
					default: m_tready <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	function automatic int clamp(int v);
		if (v == 0) return 1;
		if (v > 32) return 32;
		return v;
	endfunction

	function automatic int vidx(int x, int y, int z);
		return x + 32*y + 1024*z;
	endfunction

	function automatic bit in_vol(int x, int y, int z);
		return x < sx && y < sy && z < sz;
	endfunction

	function automatic bit safe_proc(int x, int y, int z);
		if (!in_vol(x, y, z)) return 1;
		if (!loaded[vidx(x, y, z)]) return 0;
		if (!solid[vidx(x, y, z)]) return 1;
		if (x > 0 && !loaded[vidx(x-1, y, z)]) return 0;
		if (x + 1 < sx && !loaded[vidx(x+1, y, z)]) return 0;
		if (y > 0 && !loaded[vidx(x, y-1, z)]) return 0;
		if (y + 1 < sy && !loaded[vidx(x, y+1, z)]) return 0;
		if (z > 0 && !loaded[vidx(x, y, z-1)]) return 0;
		if (z + 1 < sz && !loaded[vidx(x, y, z+1)]) return 0;
		return 1;
	endfunction

	task automatic push(logic [1:0] cmd, int x, int y, int z, bit occ);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {occ, z[4:0], y[4:0], x[4:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (cmd == vbf_pkg::CMD_CLEAR) cleared = 1;
	endtask

	task automatic load(int x, int y, int z, bit occ);
		push(vbf_pkg::CMD_LOAD, x, y, z, occ);
		if (in_vol(x, y, z)) begin
			loaded[vidx(x, y, z)] = 1;
			solid[vidx(x, y, z)]  = occ;
			n_items++;
		end
	endtask

	task automatic process(int x, int y, int z);
		if (safe_proc(x, y, z)) begin
			push(vbf_pkg::CMD_PROC, x, y, z, $urandom_range(1));
			n_items++;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (cleared ? SWEEP : SETTLE) @(posedge clk);
		cleared = 0;
	endtask

	task automatic set_sizes(int vx, int vy, int vz);
		drain();
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_SIZE_X;
		cfg_wdata <= vx[5:0];
		@(posedge clk);
		cfg_addr  <= REG_SIZE_Y;
		cfg_wdata <= vy[5:0];
		@(posedge clk);
		cfg_addr  <= REG_SIZE_Z;
		cfg_wdata <= vz[5:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sx = clamp(vx);
		sy = clamp(vy);
		sz = clamp(vz);
	endtask

	task automatic fill_box(int x0, int y0, int z0, int dx, int dy, int dz);
		for (int z = z0; z < z0 + dz; z++)
			for (int y = y0; y < y0 + dy; y++)
				for (int x = x0; x < x0 + dx; x++)
					load(x, y, z, $urandom_range(9) < 7);
		if ($urandom_range(2) == 0) push(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
		if (sx < 32 && $urandom_range(1)) load($urandom_range(sx, 31), y0, z0, 1);
		if (sz < 32 && $urandom_range(1)) process(x0, y0, $urandom_range(sz, 31));
		for (int z = z0; z < z0 + dz; z++)
			for (int y = y0; y < y0 + dy; y++)
				for (int x = x0; x < x0 + dx; x++)
					process(x, y, z);
	endtask

	initial begin
		int dx, dy, dz;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_addr  <= REG_SIZE_X;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= vbf_pkg::CMD_LOAD;
		sx = 32;
		sy = 32;
		sz = 32;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// single voxel volume, sizes written as zero
		set_sizes(0, 0, 0);
		load(0, 0, 0, 1);
		load(5, 0, 0, 1);
		push(CMD_NONE, 31, 31, 31, 1);
		process(0, 0, 0);
		process(1, 0, 0);
		process(0, 0, 0);
		push(vbf_pkg::CMD_CLEAR, 0, 0, 0, 0);
		process(0, 0, 0);
		load(0, 0, 0, 0);
		process(0, 0, 0);

		// full volume through oversized values, corners at both ends
		set_sizes(63, 32, 40);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_SPARE;
		cfg_wdata <= 6'h2a;
		@(posedge clk);
		cfg_we <= 1'b0;
		squeeze = 1;
		fill_box(30, 30, 30, 2, 2, 2);
		fill_box(0, 0, 0, 2, 2, 1);

		while (n_items < 100) begin
			if ($urandom_range(3) == 0)
				set_sizes(32, $urandom_range(33, 63), $urandom_range(20, 32));
			else
				set_sizes($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6));
			dx = $urandom_range(1, sx < 3 ? sx : 3);
			dy = $urandom_range(1, sy < 3 ? sy : 3);
			dz = $urandom_range(1, sz < 3 ? sz : 3);
			if ($urandom_range(5) == 0) push(vbf_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, 0);
			fill_box($urandom_range(sx - dx), $urandom_range(sy - dy),
				$urandom_range(sz - dz), dx, dy, dz);
		end

		drain();
		if (fails == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### voxel_boundary_faces.f
rtl/vbf_pkg.sv
rtl/vbf_addr.sv
rtl/voxel_boundary_faces.sv
dv/vbf_checker.sv
dv/tb_voxel_boundary_faces.sv
